FILE: rtl/core/fuvt_pkg.sv
// Shared constants and types for the first-unique-value tracker.
`default_nettype none

package fuvt_pkg;

  // Default depth of the distinct-value chain and width of the compared value
  localparam int FUVT_DISTINCT_MAX = 64;
  localparam int FUVT_VALUE_BITS   = 32;

  // Stream payload widths
  localparam int FUVT_DATA_BITS = 32;
  localparam int FUVT_USER_BITS = 2;

  // Bit positions inside the result tuser
  localparam int FUVT_USER_FOUND = 0;
  localparam int FUVT_USER_FULL  = 1;

  // Control part of a request travelling down the chain
  typedef struct packed {
    logic valid;  // stage holds a request
    logic done;   // value matched a cell or was stored in one
    logic found;  // a unique value has been picked already
  } fuvt_tok_t;

endpackage

`default_nettype wire

FILE: rtl/core/fuvt_cell.sv
// One cell of the chain: a stored distinct value, its flags and one request stage.
`default_nettype none

module fuvt_cell
  import fuvt_pkg::*;
#(
  parameter int VALUE_BITS = FUVT_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire fuvt_tok_t             ctrl_in,
  input  wire logic [VALUE_BITS-1:0] val_in,
  input  wire logic [VALUE_BITS-1:0] first_in,
  output fuvt_tok_t                  ctrl_out,
  output logic [VALUE_BITS-1:0]      val_out,
  output logic [VALUE_BITS-1:0]      first_out
);

  // Cell contents
  logic [VALUE_BITS-1:0] cell_value;
  logic                  used;
  logic                  repeated;

  logic                  live;
  logic                  match;
  logic                  claim;
  logic                  used_next;
  logic                  repeated_next;
  logic [VALUE_BITS-1:0] cell_value_next;
  fuvt_tok_t             ctrl_next;
  logic [VALUE_BITS-1:0] first_next;

  // Compare, claim and unique pick for the request in front of this cell
  always_comb begin
    live            = advance && ctrl_in.valid;
    match           = used && (cell_value == val_in);
    claim           = !used && !ctrl_in.done;
    used_next       = used | claim;
    repeated_next   = (repeated | match) & ~claim;
    cell_value_next = claim ? val_in : cell_value;

    ctrl_next       = ctrl_in;
    ctrl_next.done  = ctrl_in.done | match | claim;
    first_next      = first_in;
    if (!ctrl_in.found && used_next && !repeated_next) begin
      ctrl_next.found = 1'b1;
      first_next      = cell_value_next;
    end
  end

  // Cell flags; cleared on reset, so an unwritten value is never compared
  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= 1'b0;
      repeated <= 1'b0;
    end else if (live) begin
      used     <= used_next;
      repeated <= repeated_next;
    end
  end

  // Stored value
  always_ff @(posedge clk) begin
    if (live && claim) begin
      cell_value <= val_in;
    end
  end

  // Request stage toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (advance) begin
      ctrl_out <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      val_out   <= val_in;
      first_out <= first_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/first_unique_value_tracker.sv
// Top level: chain of distinct-value cells with an output register.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-----------------------------------------
//   s_      | in  | s_tvalid/s_tready  | tdata[31:0] value
//   m_      | out | m_tvalid/m_tready  | tdata[31:0] first_value,
//           |     |                    | tuser[0] found, tuser[1] store_full
//
// One request per cycle sustained while m_tready does not hold the chain; each result
// passes through the request stage of every cell and then the output register.
// Reset clears the used and repeated flags of every cell.
// While a result waits with m_tready low, the whole chain holds and s_tready is low.
`default_nettype none

module first_unique_value_tracker
  import fuvt_pkg::*;
#(
  parameter int DISTINCT_MAX = FUVT_DISTINCT_MAX,
  parameter int VALUE_BITS   = FUVT_VALUE_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [FUVT_DATA_BITS-1:0] s_tdata,   // [31:0] value
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [FUVT_DATA_BITS-1:0]      m_tdata,   // [31:0] first_value
  output logic [FUVT_USER_BITS-1:0]      m_tuser    // [0] found, [1] store_full
);

  fuvt_tok_t             ctrl  [DISTINCT_MAX+1];
  logic [VALUE_BITS-1:0] val   [DISTINCT_MAX+1];
  logic [VALUE_BITS-1:0] first [DISTINCT_MAX+1];
  logic                  advance;

  // Chain moves whenever the output register is free or being emptied
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // Head of the chain
  assign ctrl[0]  = '{valid: s_tvalid, done: 1'b0, found: 1'b0};
  assign val[0]   = VALUE_BITS'(s_tdata);
  assign first[0] = '0;

  // Cell chain
  for (genvar i = 0; i < DISTINCT_MAX; i++) begin : g_cell
    fuvt_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .ctrl_in   (ctrl[i]),
      .val_in    (val[i]),
      .first_in  (first[i]),
      .ctrl_out  (ctrl[i+1]),
      .val_out   (val[i+1]),
      .first_out (first[i+1])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= ctrl[DISTINCT_MAX].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata                  <= FUVT_DATA_BITS'(first[DISTINCT_MAX]);
      m_tuser[FUVT_USER_FOUND] <= ctrl[DISTINCT_MAX].found;
      m_tuser[FUVT_USER_FULL]  <= !ctrl[DISTINCT_MAX].done;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fuvt_checker.sv
// Port-level checks for the first-unique-value tracker, bound to the top level.
`default_nettype none

module fuvt_assertions
  import fuvt_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tready,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [FUVT_DATA_BITS-1:0] m_tdata,
  input wire logic [FUVT_USER_BITS-1:0] m_tuser
);

  // A held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // No unique value means a zero first_value
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[FUVT_USER_FOUND] |-> m_tdata == '0)
    else $error("first_value nonzero without found");

  // An empty output register never holds off a request
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind first_unique_value_tracker fuvt_assertions u_fuvt_assertions (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: bench/fuvt_checker.sv
// Checker for the first-unique-value tracker: predicts every result and compares it.
module fuvt_checker
  import fuvt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [FUVT_DATA_BITS-1:0] s_tdata,   // [31:0] value
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [FUVT_DATA_BITS-1:0] m_tdata,   // [31:0] first_value
  input  logic [FUVT_USER_BITS-1:0] m_tuser,   // [0] found, [1] store_full
  output int                        failures,
  output int                        results_due
);

  typedef struct packed {
    logic [FUVT_DATA_BITS-1:0] first_value;
    logic                      found;
    logic                      store_full;
  } unique_result_t;

  // Predictor copy of the distinct-value store
  logic [FUVT_VALUE_BITS-1:0] cell_value    [FUVT_DISTINCT_MAX];
  logic                       cell_used     [FUVT_DISTINCT_MAX];
  logic                       cell_repeated [FUVT_DISTINCT_MAX];

  unique_result_t results_ahead[$];
  int fail_count = 0;
  int due_count  = 0;

  assign failures    = fail_count;
  assign results_due = due_count;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Adds one value to the predicted store and works out the result it causes
  function automatic unique_result_t track_value(input logic [FUVT_DATA_BITS-1:0] raw);
    logic [FUVT_VALUE_BITS-1:0] v;
    logic                       hit;
    int                         free_cell;
    unique_result_t             res;
    v         = raw[FUVT_VALUE_BITS-1:0];
    hit       = 1'b0;
    free_cell = -1;
    res       = '0;
    // match against every used cell, remember the first free one
    for (int i = 0; i < FUVT_DISTINCT_MAX; i++) begin
      if (cell_used[i]) begin
        if (cell_value[i] == v) begin
          cell_repeated[i] = 1'b1;
          hit = 1'b1;
        end
      end else if (free_cell < 0) begin
        free_cell = i;
      end
    end
    // new value: store it, or drop it when no cell is free
    if (!hit) begin
      if (free_cell >= 0) begin
        cell_value[free_cell]    = v;
        cell_used[free_cell]     = 1'b1;
        cell_repeated[free_cell] = 1'b0;
      end else begin
        res.store_full = 1'b1;
      end
    end
    // oldest cell still seen only once
    for (int i = 0; i < FUVT_DISTINCT_MAX; i++) begin
      if (cell_used[i] && !cell_repeated[i] && !res.found) begin
        res.first_value = FUVT_DATA_BITS'(cell_value[i]);
        res.found       = 1'b1;
      end
    end
    return res;
  endfunction

  // Track requests and compare results in order
  always @(posedge clk) begin
    unique_result_t want;
    if (rst) begin
      for (int i = 0; i < FUVT_DISTINCT_MAX; i++) begin
        cell_value[i]    = '0;
        cell_used[i]     = 1'b0;
        cell_repeated[i] = 1'b0;
      end
      results_ahead.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_ahead.size() == 0) begin
          report_mismatch($sformatf("result with no request pending, tdata %h", m_tdata));
        end else begin
          want = results_ahead.pop_front();
          if (m_tdata !== want.first_value)
            report_mismatch($sformatf("first_value got %h want %h",
                                      m_tdata, want.first_value));
          if (m_tuser[FUVT_USER_FOUND] !== want.found)
            report_mismatch($sformatf("found got %b want %b",
                                      m_tuser[FUVT_USER_FOUND], want.found));
          if (m_tuser[FUVT_USER_FULL] !== want.store_full)
            report_mismatch($sformatf("store_full got %b want %b",
                                      m_tuser[FUVT_USER_FULL], want.store_full));
        end
      end
      if (s_tvalid && s_tready) results_ahead = {results_ahead, track_value(s_tdata)};
    end
    due_count = results_ahead.size();
  end

endmodule

FILE: bench/testbench.sv
// Top of the tracker bench: clock, reset, request stimulus and verdict.
module testbench;
  import fuvt_pkg::*;

  localparam int RANDOM_PER_PHASE = 280;
  localparam int DRAIN_CYCLES     = 2 * (FUVT_DISTINCT_MAX + 1);

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic [FUVT_DATA_BITS-1:0] s_tdata  = '0;
  logic                      m_tready = 1'b0;
  logic                      s_tready;
  logic                      m_tvalid;
  logic [FUVT_DATA_BITS-1:0] m_tdata;   // [31:0] first_value
  logic [FUVT_USER_BITS-1:0] m_tuser;   // [0] found, [1] store_full

  int failures;
  int results_due;
  int send_idle = 31;
  int recv_idle = 70;

  logic [FUVT_DATA_BITS-1:0] sent_values[$];

  // Opening requests: zero as a real value, all-ones, repeats and third arrivals,
  // single-bit patterns, and a point where no unique value is left
  logic [FUVT_DATA_BITS-1:0] opening_values [15] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
    32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 32'h1234_5678
  };

  first_unique_value_tracker uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  fuvt_checker check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .failures    (failures),
    .results_due (results_due)
  );

  always #5 clk = ~clk;

  // Receiver stalls at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Mostly repeats of earlier values, now and then a fresh one, so the store
  // fills up partway through and dropped values come back again later
  function automatic logic [FUVT_DATA_BITS-1:0] pick_value();
    if (sent_values.size() == 0 || $urandom_range(7) == 0)
      return $urandom();
    return sent_values[$urandom_range(sent_values.size() - 1)];
  endfunction

  // One request, with random idle cycles ahead of it
  task automatic push_value(input logic [FUVT_DATA_BITS-1:0] v);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    sent_values = {sent_values, v};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Main sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (opening_values[i]) push_value(opening_values[i]);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 31;
          recv_idle = 70;
        end
        1: begin
          send_idle = 70;
          recv_idle = 31;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) push_value(pick_value());
    end
    s_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
